[hdl/tmse_pkg.sv]
// Package for the Turing machine step engine: command codes, register
// indexes, payload and rule structs, controller/datapath handshake structs.
// No dependencies.
`default_nettype none

package tmse_pkg;

  // command codes
  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_TAPE_WR = 3'd1;
  localparam logic [2:0] CMD_START   = 3'd2;
  localparam logic [2:0] CMD_STEP    = 3'd3;
  localparam logic [2:0] CMD_TAPE_RD = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_RULE_COUNT  = 2'd0;
  localparam logic [1:0] CFG_START_STATE = 2'd1;
  localparam logic [1:0] CFG_START_HEAD  = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] rule_index;
    logic [5:0] rule_from_state;
    logic [7:0] rule_read_symbol;
    logic [5:0] rule_next_state;
    logic [7:0] rule_write_symbol;
    logic       rule_move_right;
    logic [7:0] tape_address;
    logic [7:0] tape_symbol;
  } tmse_in_t;

  typedef struct packed {
    logic [5:0] machine_state;
    logic [7:0] head_position;
    logic [7:0] written_symbol;
    logic       halted;
    logic       head_out_of_range;
  } tmse_out_t;

  typedef struct packed {
    logic [5:0] from_state;
    logic [7:0] read_symbol;
    logic [5:0] next_state;
    logic [7:0] write_symbol;
    logic       move_right;
  } tmse_rule_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // register the accepted item
    logic exec;        // load rule, write tape, start run
    logic tape_rd;     // issue tape read (head or tape_address)
    logic scan_start;  // latch symbol, clear scan counter
    logic scan_run;    // advance the rule scan
    logic fire;        // apply the matching rule
    logic nomatch;     // scan exhausted, halt
    logic report;      // load result register
  } tmse_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       halted;
    logic       match;
    logic       scan_end;
  } tmse_sts_t;

endpackage

`default_nettype wire

[hdl/tmse_ctrl.sv]
// Sequencer for the Turing machine step engine.
// Depends on tmse_pkg.
`default_nettype none

module tmse_ctrl
  import tmse_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  output logic           out_valid,
  input  wire tmse_sts_t sts,
  output tmse_ctl_t      ctl
);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_DECODE    = 5'b00010,
    ST_TAPE_WAIT = 5'b00100,
    ST_SCAN      = 5'b01000,
    ST_SPARE     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.op == CMD_STEP) begin
          if (sts.halted) begin
            ctl.report = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            ctl.tape_rd = 1'b1;
            state_nxt   = ST_TAPE_WAIT;
          end
        end else if (sts.op == CMD_TAPE_RD) begin
          ctl.tape_rd = 1'b1;
          state_nxt   = ST_TAPE_WAIT;
        end else begin
          // load, tape write, start, and unknown codes finish here
          ctl.exec   = 1'b1;
          ctl.report = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_TAPE_WAIT: begin
        if (sts.op == CMD_STEP) begin
          ctl.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end else begin
          ctl.report = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_SCAN: begin
        ctl.scan_run = 1'b1;
        if (sts.match) begin
          ctl.fire   = 1'b1;
          ctl.report = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (sts.scan_end) begin
          ctl.nomatch = 1'b1;
          ctl.report  = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ctl.report;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != ST_IDLE))
    else $error("result strobe without a command in progress");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> (state_r == ST_DECODE))
    else $error("accepted command not decoded");

  a_match_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && sts.match) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("rule match did not produce a result");

endmodule

`default_nettype wire

[hdl/tmse_dpath.sv]
// Datapath for the Turing machine step engine: configuration registers,
// rule memory, tape memory with per-cell valid bits, machine registers.
// Depends on tmse_pkg.
`default_nettype none

module tmse_dpath
  import tmse_pkg::*;
#(
  parameter int RULE_DEPTH  = 64,
  parameter int TAPE_LENGTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tmse_in_t              in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire tmse_ctl_t             ctl,
  output tmse_sts_t                  sts,
  output tmse_out_t                  out_data
);

  // rule slots reachable through the 6-bit index, tape cells reachable
  // through the 8-bit head
  localparam int RULE_SLOTS = (RULE_DEPTH < 64) ? RULE_DEPTH : 64;
  localparam int RA_W       = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int SC_W       = $clog2(RULE_SLOTS + 1);
  localparam int TAPE_DEPTH = (TAPE_LENGTH < 256) ? TAPE_LENGTH : 256;
  localparam int TA_W       = $clog2(TAPE_DEPTH);

  // configuration
  logic [6:0] rule_count_r;
  logic [5:0] start_state_r;
  logic [7:0] start_head_r;

  // machine
  logic [5:0] state_r, state_nxt;
  logic [7:0] head_r, head_nxt;
  logic       halt_r, halt_nxt;
  logic       err_r, err_nxt;

  tmse_in_t   in_r;
  tmse_out_t  out_r;
  logic [2:0] op_r;

  // tape
  logic [7:0]            tape_mem [TAPE_DEPTH];
  logic [TAPE_DEPTH-1:0] tape_vld_r;
  logic [7:0]            tape_rdata_r;
  logic                  tape_hit_r;
  logic [7:0]            tape_q;
  logic [7:0]            tape_raddr;
  logic                  tape_we;
  logic [7:0]            tape_waddr;
  logic [7:0]            tape_wdata;

  // rules and scan
  tmse_rule_t        rule_mem [RULE_SLOTS];
  tmse_rule_t        rule_q_r;
  tmse_rule_t        load_rule;
  logic              rule_we;
  logic [SC_W-1:0]   rd_idx_r;
  logic [SC_W-1:0]   scan_n;
  logic              scan_rd;
  logic              cmp_v_r;
  logic [7:0]        sym_r;
  logic              match;

  logic [7:0] written;

  assign op_r = in_r.cmd;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      in_r <= in_data;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r  <= 7'd0;
      start_state_r <= 6'd0;
      start_head_r  <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RULE_COUNT:  rule_count_r  <= cfg_data[6:0];
        CFG_START_STATE: start_state_r <= cfg_data[5:0];
        CFG_START_HEAD:  start_head_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan limit
  always_comb begin
    if (rule_count_r > 7'(RULE_SLOTS)) begin
      scan_n = SC_W'(RULE_SLOTS);
    end else begin
      scan_n = rule_count_r[SC_W-1:0];
    end
  end

  assign scan_rd  = ctl.scan_run && (rd_idx_r < scan_n);
  assign match    = cmp_v_r && (rule_q_r.from_state == state_r)
                  && (rule_q_r.read_symbol == sym_r);
  assign tape_q   = tape_hit_r ? tape_rdata_r : 8'd0;

  assign load_rule.from_state   = in_r.rule_from_state;
  assign load_rule.read_symbol  = in_r.rule_read_symbol;
  assign load_rule.next_state   = in_r.rule_next_state;
  assign load_rule.write_symbol = in_r.rule_write_symbol;
  assign load_rule.move_right   = in_r.rule_move_right;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      cmp_v_r  <= 1'b0;
    end else if (ctl.scan_start) begin
      rd_idx_r <= '0;
      cmp_v_r  <= 1'b0;
    end else begin
      cmp_v_r <= scan_rd;
      if (scan_rd) begin
        rd_idx_r <= rd_idx_r + SC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      sym_r <= tape_q;
    end
  end

  // rule memory
  always_ff @(posedge clk) begin
    if (rule_we) begin
      rule_mem[in_r.rule_index[RA_W-1:0]] <= load_rule;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_rd) begin
      rule_q_r <= rule_mem[rd_idx_r[RA_W-1:0]];
    end
  end

  // tape memory
  assign tape_raddr = (op_r == CMD_STEP) ? head_r : in_r.tape_address;

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_waddr[TA_W-1:0]] <= tape_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tape_rd) begin
      tape_rdata_r <= tape_mem[tape_raddr[TA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tape_vld_r <= '0;
      tape_hit_r <= 1'b0;
    end else begin
      if (tape_we) begin
        tape_vld_r[tape_waddr[TA_W-1:0]] <= 1'b1;
      end
      if (ctl.tape_rd) begin
        tape_hit_r <= ({1'b0, tape_raddr} < 9'(TAPE_DEPTH))
                   && tape_vld_r[tape_raddr[TA_W-1:0]];
      end
    end
  end

  // command effects
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    halt_nxt   = halt_r;
    err_nxt    = err_r;
    written    = 8'd0;
    tape_we    = 1'b0;
    tape_waddr = in_r.tape_address;
    tape_wdata = in_r.tape_symbol;
    rule_we    = 1'b0;

    if (ctl.exec) begin
      case (op_r)
        CMD_LOAD: begin
          rule_we = ({1'b0, in_r.rule_index} < 7'(RULE_SLOTS));
        end
        CMD_TAPE_WR: begin
          tape_we = ({1'b0, in_r.tape_address} < 9'(TAPE_DEPTH));
        end
        CMD_START: begin
          state_nxt = start_state_r;
          head_nxt  = start_head_r;
          if ({1'b0, start_head_r} >= 9'(TAPE_DEPTH)) begin
            halt_nxt = 1'b1;
            err_nxt  = 1'b1;
          end else begin
            halt_nxt = 1'b0;
            err_nxt  = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (ctl.fire) begin
      tape_we    = 1'b1;
      tape_waddr = head_r;
      tape_wdata = rule_q_r.write_symbol;
      state_nxt  = rule_q_r.next_state;
      written    = rule_q_r.write_symbol;
      if (rule_q_r.move_right) begin
        if ({1'b0, head_r} + 9'd1 >= 9'(TAPE_DEPTH)) begin
          halt_nxt = 1'b1;
          err_nxt  = 1'b1;
        end else begin
          head_nxt = head_r + 8'd1;
        end
      end else begin
        if (head_r == 8'd0) begin
          halt_nxt = 1'b1;
          err_nxt  = 1'b1;
        end else begin
          head_nxt = head_r - 8'd1;
        end
      end
    end

    if (ctl.nomatch) begin
      halt_nxt = 1'b1;
    end

    if (ctl.report && op_r == CMD_TAPE_RD) begin
      written = tape_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= 6'd0;
      head_r  <= 8'd1;
      halt_r  <= 1'b1;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      halt_r  <= halt_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.report) begin
      out_r.machine_state     <= state_nxt;
      out_r.head_position     <= head_nxt;
      out_r.written_symbol    <= written;
      out_r.halted            <= halt_nxt;
      out_r.head_out_of_range <= err_nxt;
    end
  end

  assign out_data     = out_r;
  assign sts.op       = op_r;
  assign sts.halted   = halt_r;
  assign sts.match    = match;
  assign sts.scan_end = (rd_idx_r >= scan_n) && !cmp_v_r;

  a_running_head_on_tape: assert property (@(posedge clk) disable iff (!rst_n)
    !halt_r |-> ({1'b0, head_r} < 9'(TAPE_DEPTH)))
    else $error("running machine with head off the tape");

  a_error_implies_halt: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> halt_r)
    else $error("range error without halt");

  a_fire_on_compare: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire |-> (cmp_v_r && !halt_r))
    else $error("rule fired without a valid compare");

endmodule

`default_nettype wire

[hdl/turing_machine_step_engine.sv]
// Top level of the Turing machine step engine: controller plus datapath.
// Depends on tmse_pkg, tmse_ctrl, tmse_dpath.
//
//  channel   ports                          transfer
//  -------   -----------------------------  ---------------------------------
//  input     start, busy, in_data           start high while busy low
//  result    out_valid, out_data            out_valid high, one cycle, no hold
//  config    cfg_we, cfg_index, cfg_data    cfg_we high, applied at once
//
// Load rule, tape write, start run and unknown codes finish after decode;
// tape read and step first read the tape. A step scans the rules in slot
// order and fires the first match; if none of the n scanned rules match
// (n = min(rule_count, slots)) it halts. The rule memory read port, one
// entry per cycle, sets the step time. A step on a halted machine changes
// nothing. Reset (rst_n low, synchronous) clears the machine and
// configuration registers at once: tape cells carry valid bits, so there is
// no clearing pass. The rule table and result register are not cleared.
// The receiver cannot stall: each result is on out_data starting in the
// cycle in which out_valid is high. A new command may be accepted in that cycle.
`default_nettype none

module turing_machine_step_engine
  import tmse_pkg::*;
#(
  parameter int RULE_DEPTH  = 64,
  parameter int TAPE_LENGTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire tmse_in_t              in_data,
  output logic                       out_valid,
  output tmse_out_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // controller/datapath link
  tmse_ctl_t ctl;
  tmse_sts_t sts;

  tmse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .ctl       (ctl)
  );

  tmse_dpath #(
    .RULE_DEPTH  (RULE_DEPTH),
    .TAPE_LENGTH (TAPE_LENGTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[tb/sv/tmse_result_checker.sv]
// Result checker for the Turing machine step engine: watches the command,
// result and register ports, predicts every result and compares it.
// Depends on tmse_pkg.
`timescale 1ns / 1ps

module tmse_result_checker
  import tmse_pkg::*;
#(
  parameter int RULE_DEPTH  = 64,
  parameter int TAPE_LENGTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  tmse_in_t              in_data,
  input  logic                  out_valid,
  input  tmse_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    results_owed
);

  // the head can only reach cells below both the tape length and 256
  localparam int HEAD_LIMIT = (TAPE_LENGTH < 256) ? TAPE_LENGTH : 256;

  tmse_rule_t rule_slots [RULE_DEPTH];
  logic [7:0] tape_cells [TAPE_LENGTH];
  logic [5:0] state_q;
  logic [7:0] head_q;
  logic       halted_q;
  logic       range_err_q;
  logic [6:0] rule_count_q;
  logic [5:0] start_state_q;
  logic [7:0] start_head_q;
  tmse_out_t  owed_status [$];

  function automatic logic [7:0] read_cell(input logic [7:0] addr);
    return (int'(addr) < TAPE_LENGTH) ? tape_cells[addr] : 8'h00;
  endfunction

  // Advance the machine by one command and return the status it reports.
  function automatic tmse_out_t apply_command(input tmse_in_t c);
    tmse_out_t  status;
    tmse_rule_t hit;
    logic [7:0] sym;
    logic [7:0] written;
    logic       fired;
    int         scan_len;
    written = 8'h00;
    case (c.cmd)
      CMD_LOAD: begin
        if (int'(c.rule_index) < RULE_DEPTH) begin
          rule_slots[c.rule_index].from_state   = c.rule_from_state;
          rule_slots[c.rule_index].read_symbol  = c.rule_read_symbol;
          rule_slots[c.rule_index].next_state   = c.rule_next_state;
          rule_slots[c.rule_index].write_symbol = c.rule_write_symbol;
          rule_slots[c.rule_index].move_right   = c.rule_move_right;
        end
      end
      CMD_TAPE_WR: begin
        if (int'(c.tape_address) < TAPE_LENGTH) tape_cells[c.tape_address] = c.tape_symbol;
      end
      CMD_START: begin
        state_q     = start_state_q;
        head_q      = start_head_q;
        halted_q    = (int'(start_head_q) >= HEAD_LIMIT);
        range_err_q = halted_q;
      end
      CMD_STEP: begin
        if (!halted_q) begin
          scan_len = (int'(rule_count_q) > RULE_DEPTH) ? RULE_DEPTH : int'(rule_count_q);
          sym      = read_cell(head_q);
          fired    = 1'b0;
          // first matching slot wins
          for (int s = 0; s < scan_len && !fired; s++) begin
            if (rule_slots[s].from_state == state_q && rule_slots[s].read_symbol == sym) begin
              hit   = rule_slots[s];
              fired = 1'b1;
            end
          end
          if (fired) begin
            if (int'(head_q) < TAPE_LENGTH) tape_cells[head_q] = hit.write_symbol;
            state_q = hit.next_state;
            written = hit.write_symbol;
            // a move off the tape leaves the head in place and halts
            if (hit.move_right) begin
              if (int'(head_q) + 1 >= HEAD_LIMIT) begin
                halted_q    = 1'b1;
                range_err_q = 1'b1;
              end else begin
                head_q = head_q + 8'd1;
              end
            end else if (head_q == 8'd0) begin
              halted_q    = 1'b1;
              range_err_q = 1'b1;
            end else begin
              head_q = head_q - 8'd1;
            end
          end else begin
            halted_q = 1'b1;
          end
        end
      end
      CMD_TAPE_RD: written = read_cell(c.tape_address);
      default: ;
    endcase
    status.machine_state     = state_q;
    status.head_position     = head_q;
    status.written_symbol    = written;
    status.halted            = halted_q;
    status.head_out_of_range = range_err_q;
    return status;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    tmse_out_t want;
    if (!rst_n) begin
      for (int k = 0; k < RULE_DEPTH; k++) rule_slots[k] = '0;
      for (int k = 0; k < TAPE_LENGTH; k++) tape_cells[k] = 8'h00;
      state_q        = 6'd0;
      head_q         = 8'd1;
      halted_q       = 1'b1;
      range_err_q    = 1'b0;
      rule_count_q   = 7'd0;
      start_state_q  = 6'd0;
      start_head_q   = 8'd1;
      mismatch_count = 0;
      owed_status.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (owed_status.size() == 0) begin
          mismatch_count++;
          $display("%0t: result expected none, actual %h", $time, out_data);
        end else begin
          want = owed_status.pop_front();
          check_field("machine_state", want.machine_state, out_data.machine_state);
          check_field("head_position", want.head_position, out_data.head_position);
          check_field("written_symbol", want.written_symbol, out_data.written_symbol);
          check_field("halted", want.halted, out_data.halted);
          check_field("head_out_of_range", want.head_out_of_range,
                      out_data.head_out_of_range);
        end
      end
      if (start && !busy) owed_status.push_back(apply_command(in_data));
      if (cfg_we) begin
        case (cfg_index)
          CFG_RULE_COUNT:  rule_count_q  = cfg_data[6:0];
          CFG_START_STATE: start_state_q = cfg_data[5:0];
          CFG_START_HEAD:  start_head_q  = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    results_owed = owed_status.size();
  end

endmodule

[tb/sv/turing_machine_step_engine_tb.sv]
// Testbench top for the Turing machine step engine: clock, reset, command
// and register stimulus, and the verdict. Depends on tmse_pkg, the engine
// RTL and tmse_result_checker.
`timescale 1ns / 1ps

module turing_machine_step_engine_tb;
  import tmse_pkg::*;

  // command codes the engine does not know; it only reports its status
  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
  // register index with no register behind it; writes are dropped
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int SLOTS        = 64;
  localparam int RANDOM_ITEMS = 1050;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  tmse_in_t              in_data   = '0;
  logic                  out_valid;
  tmse_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    mismatch_count;
  int                    results_owed;

  // Stimulus-side bookkeeping. A step may never scan a rule slot that was
  // never loaded, so the stimulus tracks loaded slots and the rule count.
  bit         slot_loaded [SLOTS];
  int         rule_count_set = 0;
  logic [5:0] start_state_set = 6'd0;
  logic [7:0] start_head_set  = 8'd1;
  // per-phase program alphabet: a few states and symbols so rules match
  logic [5:0] phase_states [4];
  logic [7:0] phase_syms [4];
  int         items_sent = 0;
  bit         gaps_on = 1'b1;

  always #6 clk = ~clk;

  turing_machine_step_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tmse_result_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // All fields random; callers overwrite the ones the command uses, so the
  // unused fields carry noise the engine must ignore.
  function automatic tmse_in_t random_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(tmse_in_t)-1:0];
  endfunction

  // One command transfer. Entered and left at a falling edge. start stays
  // high into the next call when no gap is drawn, so back-to-back
  // transfers happen; a gap drops start and puts junk on in_data.
  task automatic send_command(input tmse_in_t item);
    int gap;
    int roll;
    gap = 0;
    if (gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 92) gap = $urandom_range(8, 40);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start   <= 1'b0;
      in_data <= random_item();
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    // transfer happens at the first rising edge with busy low
    do @(posedge clk); while (busy);
    if (item.cmd == CMD_LOAD) slot_loaded[item.rule_index] = 1'b1;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic issue(input logic [2:0] code);
    tmse_in_t item;
    item     = random_item();
    item.cmd = code;
    send_command(item);
  endtask

  task automatic tape_access(input logic [2:0] code, input logic [7:0] addr,
                             input logic [7:0] sym);
    tmse_in_t item;
    item              = random_item();
    item.cmd          = code;
    item.tape_address = addr;
    item.tape_symbol  = sym;
    send_command(item);
  endtask

  task automatic load_rule(input logic [5:0] slot, input logic [5:0] from_st,
                           input logic [7:0] rd_sym, input logic [5:0] next_st,
                           input logic [7:0] wr_sym, input logic right);
    tmse_in_t item;
    item                   = random_item();
    item.cmd               = CMD_LOAD;
    item.rule_index        = slot;
    item.rule_from_state   = from_st;
    item.rule_read_symbol  = rd_sym;
    item.rule_next_state   = next_st;
    item.rule_write_symbol = wr_sym;
    item.rule_move_right   = right;
    send_command(item);
  endtask

  // A rule drawn from the current phase's alphabet; now and then the
  // symbols are fully random so rarely matching patterns appear too.
  function automatic tmse_in_t program_rule(input int slot);
    tmse_in_t item;
    item                 = random_item();
    item.cmd             = CMD_LOAD;
    item.rule_index      = slot[5:0];
    item.rule_from_state = phase_states[$urandom_range(0, 3)];
    item.rule_next_state = phase_states[$urandom_range(0, 3)];
    if ($urandom_range(0, 9) != 0) item.rule_read_symbol = phase_syms[$urandom_range(0, 3)];
    if ($urandom_range(0, 9) != 0) item.rule_write_symbol = phase_syms[$urandom_range(0, 3)];
    return item;
  endfunction

  // Step, after loading any slot inside the scan range that is still empty.
  task automatic send_step();
    int reach;
    reach = (rule_count_set > SLOTS) ? SLOTS : rule_count_set;
    for (int s = 0; s < reach; s++)
      if (!slot_loaded[s]) send_command(program_rule(s));
    issue(CMD_STEP);
  endtask

  // Drop start and wait until every result is in; every command yields a
  // result, so the engine is idle then. A few extra cycles for margin.
  task automatic settle();
    start <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write at a falling edge, enable dropped at the next falling edge.
  task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Only called while idle (after settle).
  task automatic configure(input logic [7:0] rc, input logic [7:0] st, input logic [7:0] sh);
    write_register(CFG_RULE_COUNT, rc);
    write_register(CFG_START_STATE, st);
    write_register(CFG_START_HEAD, sh);
    rule_count_set  = int'(rc[6:0]);
    start_state_set = st[5:0];
    start_head_set  = sh;
  endtask

  // One random phase: new settings, a small program with random content,
  // some tape contents near the start cell, a run start, then mostly steps
  // with reads, restarts, reloads and noise mixed in.
  task automatic run_phase();
    int         roll;
    int         reach;
    logic [7:0] rc;
    logic [7:0] sh;
    settle();
    roll = $urandom_range(0, 19);
    case (roll)
      0:       rc = 8'd0;
      1:       rc = 8'd64;
      2:       rc = 8'hFF;   // 127 after masking: scan limited to all slots
      3:       rc = 8'd65;
      default: rc = 8'($urandom_range(1, 16)) | (($urandom_range(0, 3) == 0) ? 8'h80 : 8'h00);
    endcase
    roll = $urandom_range(0, 9);
    case (roll)
      0:       sh = 8'd0;
      1:       sh = 8'd255;
      2:       sh = 8'd254;
      3:       sh = 8'd1;
      default: sh = 8'($urandom);
    endcase
    configure(rc, 8'($urandom), sh);
    phase_states[0] = start_state_set;
    phase_syms[0]   = 8'h00;   // blank cells read as zero
    for (int k = 1; k < 4; k++) begin
      phase_states[k] = 6'($urandom);
      phase_syms[k]   = 8'($urandom);
    end
    gaps_on = ($urandom_range(0, 4) != 0);

    reach = (rule_count_set > SLOTS) ? SLOTS : rule_count_set;
    repeat ($urandom_range(1, 8))
      send_command(program_rule((reach == 0) ? $urandom_range(0, SLOTS - 1)
                                             : $urandom_range(0, reach - 1)));
    repeat ($urandom_range(0, 6))
      tape_access(CMD_TAPE_WR, start_head_set + 8'($urandom_range(0, 8)) - 8'd4,
                  phase_syms[$urandom_range(0, 3)]);
    issue(CMD_START);

    repeat ($urandom_range(10, 40)) begin
      roll = $urandom_range(0, 99);
      if (roll < 78) send_step();
      else if (roll < 84) tape_access(CMD_TAPE_RD, 8'($urandom), 8'($urandom));
      else if (roll < 88) issue(CMD_START);
      else if (roll < 92) send_command(program_rule($urandom_range(0, SLOTS - 1)));
      else if (roll < 96) tape_access(CMD_TAPE_WR, 8'($urandom), 8'($urandom));
      else issue(3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)));
    end
  endtask

  initial begin
    int random_goal;
    // synchronous reset, released on a falling edge
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    send_step();                             // step right after reset: halted, no change
    tape_access(CMD_TAPE_RD, 8'h00, 8'h3C);  // blank cell reads zero
    tape_access(CMD_TAPE_WR, 8'hFF, 8'hFF);  // last cell, all-ones symbol
    tape_access(CMD_TAPE_RD, 8'hFF, 8'h00);
    tape_access(CMD_TAPE_WR, 8'h00, 8'hA5);
    issue(CMD_START);                        // reset settings: state 0, head 1
    send_step();                             // rule count zero: halts, no range error

    settle();
    configure(8'd3, 8'd63, 8'd0);
    write_register(CFG_SPARE, 8'hFF);        // no register there, must be ignored
    load_rule(6'd0, 6'd63, 8'hA5, 6'd0, 8'h5A, 1'b0);   // moves left off cell 0
    load_rule(6'd1, 6'd63, 8'hA5, 6'd42, 8'hFF, 1'b1);  // shadowed: first match wins
    load_rule(6'd2, 6'd0, 8'hFF, 6'd63, 8'h00, 1'b1);   // moves right off cell 255
    issue(CMD_START);
    send_step();                             // writes, changes state, halts off the left end
    send_step();                             // step while halted
    tape_access(CMD_TAPE_RD, 8'h00, 8'h00);

    settle();
    configure(8'd3, 8'd0, 8'd255);
    issue(CMD_START);
    send_step();                             // off the right end
    tape_access(CMD_TAPE_RD, 8'hFF, 8'h00);
    issue(CMD_START);
    send_step();                             // cell now zero, no rule matches
    issue(CMD_UNKNOWN_LO);
    issue(CMD_UNKNOWN_HI);
    load_rule(6'd63, 6'd63, 8'hFF, 6'd63, 8'hFF, 1'b1);  // all-ones fields, top slot

    // ---- random part ----
    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) run_phase();

    // drain, then allow for the longest command before the verdict
    settle();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
hdl/tmse_pkg.sv
hdl/tmse_ctrl.sv
hdl/tmse_dpath.sv
hdl/turing_machine_step_engine.sv
tb/sv/tmse_result_checker.sv
tb/sv/turing_machine_step_engine_tb.sv
